>>> rtl/core/pes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pes_pkg: shared types and constants of the periodic event scheduler
// Function codes, register indexes, adjust phases and the structs passed
// between the configuration bank, the timer engine and the top level.
// ---------------------------------------------------------------------------
package pes_pkg;

  localparam int unsigned CNT_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // shortest interval an adjusted period may take
  localparam logic [CNT_W-1:0] MIN_INTERVAL = 32'd50;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_STOP   = 2'd2,
    FUNC_ADJUST = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD          = 3'd0,
    REG_FIRST_DELAY     = 3'd1,
    REG_REPEAT_MODE     = 3'd2,
    REG_DELAYED_START   = 3'd3,
    REG_SUB_ONE_COMPARE = 3'd4,
    REG_SUB_TWO_COMPARE = 3'd5,
    REG_SUB_ONE_ENABLE  = 3'd6,
    REG_SUB_TWO_ENABLE  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ADJ_NONE      = 2'd0,
    ADJ_REQUESTED = 2'd1,
    ADJ_ACTIVE    = 2'd2
  } adj_phase_t;

  localparam logic [CNT_W-1:0] PERIOD_RESET      = 32'd1000;
  localparam logic [CNT_W-1:0] FIRST_DELAY_RESET = 32'd1000;

  typedef struct packed {
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] first_delay;
    logic             repeat_mode;
    logic             delayed_start;
    logic [CNT_W-1:0] sub_one_compare;
    logic [CNT_W-1:0] sub_two_compare;
    logic             sub_one_enable;
    logic             sub_two_enable;
  } cfg_t;

  typedef struct packed {
    logic main_event;
    logic sub_one_event;
    logic sub_two_event;
    logic running;
  } result_t;

endpackage : pes_pkg
`default_nettype wire

>>> rtl/core/pes_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pes_cfg: configuration register bank
// Write-only registers loaded from the plain write port, presented as one
// struct to the timer engine.
// ---------------------------------------------------------------------------
module pes_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pes_pkg::CNT_W-1:0]     cfg_data,
  output pes_pkg::cfg_t                      cfg
);

  pes_pkg::cfg_t regs;

  // register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.period          <= pes_pkg::PERIOD_RESET;
      regs.first_delay     <= pes_pkg::FIRST_DELAY_RESET;
      regs.repeat_mode     <= 1'b0;
      regs.delayed_start   <= 1'b0;
      regs.sub_one_compare <= '0;
      regs.sub_two_compare <= '0;
      regs.sub_one_enable  <= 1'b0;
      regs.sub_two_enable  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pes_pkg::REG_PERIOD:          regs.period          <= cfg_data;
        pes_pkg::REG_FIRST_DELAY:     regs.first_delay     <= cfg_data;
        pes_pkg::REG_REPEAT_MODE:     regs.repeat_mode     <= cfg_data[0];
        pes_pkg::REG_DELAYED_START:   regs.delayed_start   <= cfg_data[0];
        pes_pkg::REG_SUB_ONE_COMPARE: regs.sub_one_compare <= cfg_data;
        pes_pkg::REG_SUB_TWO_COMPARE: regs.sub_two_compare <= cfg_data;
        pes_pkg::REG_SUB_ONE_ENABLE:  regs.sub_one_enable  <= cfg_data[0];
        pes_pkg::REG_SUB_TWO_ENABLE:  regs.sub_two_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule : pes_cfg
`default_nettype wire

>>> rtl/core/pes_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pes_engine: timer state and single-pass next-state logic
// Holds the counter, compare target and adjust state; on each step it
// applies one item and produces the result for the output register.
// ---------------------------------------------------------------------------
module pes_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [1:0]                func,
  input  wire logic [pes_pkg::CNT_W-1:0] adjust_delta,
  input  wire pes_pkg::cfg_t             cfg,
  output pes_pkg::result_t               result
);

  logic [pes_pkg::CNT_W-1:0] tick_count, tick_count_next;
  logic [pes_pkg::CNT_W-1:0] compare_target, compare_target_next;
  logic [pes_pkg::CNT_W-1:0] adjust_amount, adjust_amount_next;
  logic                      active, active_next;
  logic                      delay_pending, delay_pending_next;
  pes_pkg::adj_phase_t       adjust_phase, adjust_phase_next;

  logic [pes_pkg::CNT_W-1:0] tick_inc;
  logic signed [pes_pkg::CNT_W+1:0] adj_sum;
  logic [pes_pkg::CNT_W-1:0] adj_interval;

  // period plus signed delta, clamped to the legal interval range
  always_comb begin
    adj_sum = $signed({2'b00, cfg.period}) +
              $signed({{2{adjust_amount[pes_pkg::CNT_W-1]}}, adjust_amount});
    if (adj_sum < $signed({2'b00, pes_pkg::MIN_INTERVAL})) begin
      adj_interval = pes_pkg::MIN_INTERVAL;
    end else if (adj_sum[pes_pkg::CNT_W]) begin
      adj_interval = '1;
    end else begin
      adj_interval = adj_sum[pes_pkg::CNT_W-1:0];
    end
  end

  assign tick_inc = tick_count + 1'b1;

  // next state and result for the current item
  always_comb begin
    tick_count_next     = tick_count;
    compare_target_next = compare_target;
    adjust_amount_next  = adjust_amount;
    active_next         = active;
    delay_pending_next  = delay_pending;
    adjust_phase_next   = adjust_phase;
    result              = '0;
    case (func)
      pes_pkg::FUNC_TICK: begin
        if (active) begin
          tick_count_next      = tick_inc;
          result.sub_one_event = cfg.sub_one_enable && (tick_inc == cfg.sub_one_compare);
          result.sub_two_event = cfg.sub_two_enable && (tick_inc == cfg.sub_two_compare);
          if (tick_inc == compare_target) begin
            result.main_event = 1'b1;
            if (cfg.repeat_mode || cfg.delayed_start) begin
              tick_count_next = '0;
            end else begin
              active_next = 1'b0;
            end
            if (delay_pending) begin
              compare_target_next = cfg.period;
              delay_pending_next  = 1'b0;
            end
            case (adjust_phase)
              pes_pkg::ADJ_REQUESTED: begin
                compare_target_next = adj_interval;
                adjust_phase_next   = pes_pkg::ADJ_ACTIVE;
              end
              pes_pkg::ADJ_ACTIVE: begin
                compare_target_next = cfg.period;
                adjust_phase_next   = pes_pkg::ADJ_NONE;
              end
              default: ;
            endcase
          end
        end
      end
      pes_pkg::FUNC_START: begin
        tick_count_next     = '0;
        adjust_phase_next   = pes_pkg::ADJ_NONE;
        delay_pending_next  = cfg.delayed_start;
        compare_target_next = cfg.delayed_start ? cfg.first_delay : cfg.period;
        active_next         = 1'b1;
      end
      pes_pkg::FUNC_STOP: begin
        active_next = 1'b0;
      end
      pes_pkg::FUNC_ADJUST: begin
        adjust_amount_next = adjust_delta;
        adjust_phase_next  = pes_pkg::ADJ_REQUESTED;
      end
      default: ;
    endcase
    result.running = active_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      compare_target <= '0;
      adjust_amount  <= '0;
      active         <= 1'b0;
      delay_pending  <= 1'b0;
      adjust_phase   <= pes_pkg::ADJ_NONE;
    end else if (step) begin
      tick_count     <= tick_count_next;
      compare_target <= compare_target_next;
      adjust_amount  <= adjust_amount_next;
      active         <= active_next;
      delay_pending  <= delay_pending_next;
      adjust_phase   <= adjust_phase_next;
    end
  end

`ifndef SYNTHESIS
  // a start always leaves the counter running and cleared
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (step && func == pes_pkg::FUNC_START) |=> (active && tick_count == '0))
    else $error("start did not arm the counter");

  // a main event only on a tick while running
  a_main_needs_tick: assert property (@(posedge clk) disable iff (rst)
    (step && result.main_event) |-> (func == pes_pkg::FUNC_TICK && active))
    else $error("main event outside a running tick");

  // the counter only moves on ticks or starts
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (step && (func == pes_pkg::FUNC_STOP || func == pes_pkg::FUNC_ADJUST))
      |=> $stable(tick_count))
    else $error("counter moved on stop or adjust");

  // an adjusted interval is never shorter than the minimum
  a_adj_min: assert property (@(posedge clk) disable iff (rst)
    (step && result.main_event && adjust_phase == pes_pkg::ADJ_REQUESTED)
      |=> (compare_target >= pes_pkg::MIN_INTERVAL))
    else $error("adjusted interval below minimum");
`endif

endmodule : pes_engine
`default_nettype wire

>>> rtl/core/periodic_event_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// periodic_event_scheduler: compare-match timer with one-period adjust
// Input register, single-pass timer engine and output register; tick,
// start, stop and adjust beats each give one result beat.
// ---------------------------------------------------------------------------
// A beat accepted into the input register passes through the timer engine into
// the output register; one beat per cycle while the output is not stalled, with
// the timer state updating in a single pass. A stalled output holds its beat while
// one more input beat waits in the input register. Synchronous active-high reset
// clears the timer (stopped) and loads register defaults; the block takes beats the cycle after reset.
module periodic_event_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pes_pkg::CNT_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    func,
  input  wire logic [pes_pkg::CNT_W-1:0]     adjust_delta,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               main_event,
  output logic                               sub_one_event,
  output logic                               sub_two_event,
  output logic                               running
);

  pes_pkg::cfg_t    cfg;
  pes_pkg::result_t result;
  pes_pkg::result_t result_q;

  logic                      item_valid;
  logic [1:0]                item_func;
  logic [pes_pkg::CNT_W-1:0] item_delta;
  logic                      advance;
  logic                      in_take;

  pes_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake between the stages
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_func  <= func;
      item_delta <= adjust_delta;
    end
  end

  pes_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .func         (item_func),
    .adjust_delta (item_delta),
    .cfg          (cfg),
    .result       (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign main_event    = result_q.main_event;
  assign sub_one_event = result_q.sub_one_event;
  assign sub_two_event = result_q.sub_two_event;
  assign running       = result_q.running;

endmodule : periodic_event_scheduler
`default_nettype wire

>>> sim/periodic_event_scheduler_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_event_scheduler_tb: self-checking bench for the event scheduler
// Sends tick, start, stop and adjust beats with random valid gaps and output
// stalls, predicts every result beat with a behavioral timer model and checks
// each beat field by field, across directed and random register settings.
// ---------------------------------------------------------------------------
module periodic_event_scheduler_tb;
  import pes_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int MAX_WAIT        = 13;
  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_PHASES   = 10;
  localparam int BEATS_PER_PHASE = 100;

  typedef struct {
    func_t            op;
    logic [CNT_W-1:0] delta;
  } beat_t;

  // block ports, the driven ones known from time zero
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CNT_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [1:0]           func         = FUNC_TICK;
  logic [CNT_W-1:0]     adjust_delta = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 main_event;
  logic                 sub_one_event;
  logic                 sub_two_event;
  logic                 running;

  // timer model state and its copy of the registers
  cfg_t             timer_cfg;
  logic [CNT_W-1:0] timer_count            = '0;
  logic [CNT_W-1:0] timer_target           = '0;
  logic             timer_running          = 1'b0;
  logic             first_interval_pending = 1'b0;
  adj_phase_t       adjust_state           = ADJ_NONE;
  logic [CNT_W-1:0] adjust_value           = '0;

  beat_t   pending_beats[$];
  result_t expected_events[$];
  beat_t   next_beat;
  result_t want;
  int      gap_left    = 0;
  int      stall_left  = 0;
  int      idle_cycles = 0;
  int      errors      = 0;
  bit      send_calm   = 1'b0;
  bit      recv_calm   = 1'b0;

  periodic_event_scheduler uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .adjust_delta  (adjust_delta),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .main_event    (main_event),
    .sub_one_event (sub_one_event),
    .sub_two_event (sub_two_event),
    .running       (running)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // period plus signed delta, floored at the minimum interval, saturated on top
  function automatic logic [CNT_W-1:0] adjusted_period();
    longint sum;
    sum = longint'(timer_cfg.period) + longint'($signed(adjust_value));
    if (sum < longint'(MIN_INTERVAL)) return MIN_INTERVAL;
    if (sum > 64'sh0000_0000_FFFF_FFFF) return '1;
    return sum[CNT_W-1:0];
  endfunction

  // apply one beat to the timer model and return the result it gives
  function automatic result_t advance_timer(func_t op, logic [CNT_W-1:0] delta);
    result_t r;
    r = '0;
    case (op)
      FUNC_TICK: begin
        if (timer_running) begin
          timer_count = timer_count + 1'b1;
          r.sub_one_event = timer_cfg.sub_one_enable &&
                            timer_count == timer_cfg.sub_one_compare;
          r.sub_two_event = timer_cfg.sub_two_enable &&
                            timer_count == timer_cfg.sub_two_compare;
          if (timer_count == timer_target) begin
            r.main_event = 1'b1;
            // repeat or delayed-start mode clears, one-shot stops and holds the count
            if (timer_cfg.repeat_mode || timer_cfg.delayed_start) timer_count = '0;
            else timer_running = 1'b0;
            if (first_interval_pending) begin
              timer_target = timer_cfg.period;
              first_interval_pending = 1'b0;
            end
            // one adjusted interval, then back to the plain period
            if (adjust_state == ADJ_REQUESTED) begin
              timer_target = adjusted_period();
              adjust_state = ADJ_ACTIVE;
            end else if (adjust_state == ADJ_ACTIVE) begin
              timer_target = timer_cfg.period;
              adjust_state = ADJ_NONE;
            end
          end
        end
      end
      FUNC_START: begin
        timer_count = '0;
        adjust_state = ADJ_NONE;
        first_interval_pending = timer_cfg.delayed_start;
        timer_target = timer_cfg.delayed_start ? timer_cfg.first_delay : timer_cfg.period;
        timer_running = 1'b1;
      end
      FUNC_STOP: begin
        timer_running = 1'b0;
      end
      FUNC_ADJUST: begin
        adjust_value = delta;
        adjust_state = ADJ_REQUESTED;
      end
    endcase
    r.running = timer_running;
    return r;
  endfunction

  // calm mode or a coin toss gives no wait, else a wait drawn from 0 to MAX_WAIT
  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // input driver: predicts each accepted beat, then presents the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_events.push_back(advance_timer(func_t'(func), adjust_delta));
        gap_left = draw_wait(send_calm);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && pending_beats.size() != 0) begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          func <= next_beat.op;
          adjust_delta <= next_beat.delta;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  task automatic compare_field(string name, logic exp_bit, logic got_bit);
    if (got_bit !== exp_bit) begin
      $display("%0t: %s mismatch: expected %b, actual %b", $time, name, exp_bit, got_bit);
      errors++;
    end
  endtask

  // output monitor: checks each result beat, then draws the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %b%b%b%b",
                   $time, main_event, sub_one_event, sub_two_event, running);
          errors++;
        end else begin
          want = expected_events.pop_front();
          compare_field("main_event", want.main_event, main_event);
          compare_field("sub_one_event", want.sub_one_event, sub_one_event);
          compare_field("sub_two_event", want.sub_two_event, sub_two_event);
          compare_field("running", want.running, running);
        end
        stall_left = draw_wait(recv_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** periodic_event_scheduler: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  // write every register, only while the block is idle
  task automatic load_config(cfg_t c);
    write_reg(REG_PERIOD, c.period);
    write_reg(REG_FIRST_DELAY, c.first_delay);
    write_reg(REG_REPEAT_MODE, CNT_W'(c.repeat_mode));
    write_reg(REG_DELAYED_START, CNT_W'(c.delayed_start));
    write_reg(REG_SUB_ONE_COMPARE, c.sub_one_compare);
    write_reg(REG_SUB_TWO_COMPARE, c.sub_two_compare);
    write_reg(REG_SUB_ONE_ENABLE, CNT_W'(c.sub_one_enable));
    write_reg(REG_SUB_TWO_ENABLE, CNT_W'(c.sub_two_enable));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    timer_cfg = c;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_events.size() != 0);
  endtask

  task automatic push_beats(func_t op, logic [CNT_W-1:0] delta, int n = 1);
    repeat (n) pending_beats.push_back('{op, delta});
  endtask

  // mostly small deltas, plus clamping, saturating and fully random ones
  function automatic logic [CNT_W-1:0] random_delta();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 30) - 15;
      5, 6:          return $urandom;
      7:             return 32'h8000_0000 | $urandom_range(0, 255);
      8:             return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default:       return -$urandom_range(1, 200);
    endcase
  endfunction

  // short periods so main events come often, a few long ones
  function automatic cfg_t random_cfg();
    cfg_t c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c.period = $urandom_range(1, 12);
      6, 7:             c.period = $urandom_range(40, 70);
      8:                c.period = $urandom_range(1, 3);
      default:          c.period = $urandom | 32'h8000_0000;
    endcase
    c.first_delay = ($urandom_range(0, 7) == 0) ? ($urandom | 32'h1) : $urandom_range(1, 15);
    c.repeat_mode = 1'($urandom_range(0, 1));
    c.delayed_start = 1'($urandom_range(0, 1));
    c.sub_one_compare = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 14);
    c.sub_two_compare = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 14);
    c.sub_one_enable = 1'($urandom_range(0, 1));
    c.sub_two_enable = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // a start, then mostly ticks; one-shot settings restart more often
  task automatic queue_random(int n);
    int start_w;
    int stop_w;
    int pick;
    start_w = (timer_cfg.repeat_mode || timer_cfg.delayed_start) ? 3 : 12;
    stop_w = start_w + 2;
    push_beats(FUNC_START, $urandom);
    repeat (n - 1) begin
      pick = $urandom_range(0, 99);
      if (pick < start_w) push_beats(FUNC_START, $urandom);
      else if (pick < stop_w) push_beats(FUNC_STOP, $urandom);
      else if (pick < stop_w + 7) push_beats(FUNC_ADJUST, random_delta());
      else push_beats(FUNC_TICK, $urandom);
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // delayed start, sub events, same-tick events, clamped adjust, stop
    load_config('{period: 32'd4, first_delay: 32'd3, repeat_mode: 1'b1,
                  delayed_start: 1'b1, sub_one_compare: 32'd2, sub_two_compare: 32'd4,
                  sub_one_enable: 1'b1, sub_two_enable: 1'b1});
    push_beats(FUNC_TICK, $urandom);
    push_beats(FUNC_START, $urandom);
    push_beats(FUNC_TICK, $urandom, 3);
    push_beats(FUNC_TICK, $urandom, 4);
    push_beats(FUNC_ADJUST, 32'h8000_0000);
    push_beats(FUNC_TICK, $urandom, 4);
    push_beats(FUNC_STOP, $urandom);
    push_beats(FUNC_TICK, $urandom);
    push_beats(FUNC_ADJUST, 32'h7FFF_FFFF);
    push_beats(FUNC_START, $urandom);
    push_beats(FUNC_TICK, $urandom);
    wait_drained();

    // register maxima, saturating adjust, one-shot
    load_config('{period: '1, first_delay: '1, repeat_mode: 1'b0,
                  delayed_start: 1'b0, sub_one_compare: '1, sub_two_compare: '0,
                  sub_one_enable: 1'b1, sub_two_enable: 1'b1});
    push_beats(FUNC_START, $urandom);
    push_beats(FUNC_ADJUST, 32'h7FFF_FFFF);
    push_beats(FUNC_TICK, $urandom, 2);
    push_beats(FUNC_STOP, $urandom);
    wait_drained();

    // register minima: one-shot fires on the first tick, then holds
    load_config('{period: 32'd1, first_delay: 32'd1, repeat_mode: 1'b0,
                  delayed_start: 1'b0, sub_one_compare: 32'd1, sub_two_compare: 32'd1,
                  sub_one_enable: 1'b1, sub_two_enable: 1'b1});
    push_beats(FUNC_START, $urandom);
    push_beats(FUNC_TICK, $urandom, 2);
    push_beats(FUNC_START, $urandom);
    push_beats(FUNC_ADJUST, 32'hFFFF_FFFB);
    push_beats(FUNC_TICK, $urandom);
    wait_drained();

    // random settings, each phase drained before the next write
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_calm = (p == 2 || p == 5);
      recv_calm = (p == 3 || p == 5);
      load_config(random_cfg());
      queue_random(BEATS_PER_PHASE);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    errors += expected_events.size();
    if (errors == 0) $display("** periodic_event_scheduler: PASSED **");
    else $display("** periodic_event_scheduler: FAILED **");
    $finish;
  end

endmodule
